/* sv/pitb_pkg.sv */
// Shared constants for the barycentric point-in-triangle pipeline.
// Holds the default coordinate width, the pipeline depth and the operand tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pitb_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // Register stages between the input beat and the result beat
    localparam int PIPE_STAGES = 8;

    // Vectors formed in the first stage
    localparam int NUM_VECS = 3;
    localparam int VEC_E1   = 0;
    localparam int VEC_E2   = 1;
    localparam int VEC_D    = 2;

    // Dot products
    localparam int NUM_DOTS = 5;
    localparam int DOT_D11  = 0;
    localparam int DOT_D12  = 1;
    localparam int DOT_D22  = 2;
    localparam int DOT_D1P  = 3;
    localparam int DOT_D2P  = 4;

    localparam int DOT_A [NUM_DOTS] = '{VEC_E1, VEC_E1, VEC_E2, VEC_E1, VEC_E2};
    localparam int DOT_B [NUM_DOTS] = '{VEC_E1, VEC_E2, VEC_E2, VEC_D,  VEC_D};

    // Second-level products: g = m0 - m1, nu = m2 - m3, nv = m4 - m5
    localparam int NUM_MULS = 6;
    localparam int MUL_A [NUM_MULS] = '{DOT_D11, DOT_D12, DOT_D22, DOT_D12, DOT_D11, DOT_D12};
    localparam int MUL_B [NUM_MULS] = '{DOT_D22, DOT_D12, DOT_D1P, DOT_D2P, DOT_D2P, DOT_D1P};

    // Width of the result beat's data bus
    localparam int OUT_TDATA_W = 8;

endpackage

`default_nettype wire

/* sv/point_in_triangle_barycentric.sv */
// Top level of the barycentric point-in-triangle test: an eight-stage pipeline.
// Depends on pitb_pkg for the operand tables and pipeline depth.
// An accepted beat moves in order through vec, term, dot, pp, prod, g/nu/nv, sum and inside registers.
// Throughput: one beat per cycle; each stage holds its beat only while the next one is full.
// The slowest stages are the split 36x36 products (four partial products each)
// and the 74-bit add and compare at the end.
// Reset (rst_n low, asynchronous) clears every stage valid bit; data registers keep no reset.
`timescale 1ns / 1ps
`default_nettype none

module point_in_triangle_barycentric #(
    parameter int  COORD_WIDTH = pitb_pkg::COORD_WIDTH_DEF,
    localparam int IN_BITS     = 12 * COORD_WIDTH + 6,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // point_x, point_y, point_z, corner_x, corner_y, corner_z,
    // edge1_x, edge1_y, edge1_z, edge2_x, edge2_y, edge2_z, zero pad
    input  wire logic [IN_TDATA_W-1:0]             s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // inside_res, zero pad
    output logic [pitb_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int EW   = CW + 1;
    localparam int PRW  = 2 * EW;
    localparam int DW   = 2 * EW + 2;
    localparam int H    = DW / 2;
    localparam int PW   = 2 * DW;
    localparam int GW   = PW + 1;
    localparam int SW   = PW + 2;
    localparam int NSTG = pitb_pkg::PIPE_STAGES;
    localparam int NV   = pitb_pkg::NUM_VECS;
    localparam int ND   = pitb_pkg::NUM_DOTS;
    localparam int NM   = pitb_pkg::NUM_MULS;

    // ------------------------------------------------------------------
    // Handshake: per-stage valid bits, ready ripples back from the output
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] vin;
    logic [NSTG-1:0] en;
    logic [NSTG:0]   rdy;

    assign rdy[NSTG] = m_tready;

    genvar gi;
    generate
        for (gi = 0; gi < NSTG; gi++)
        begin : g_ctl
            assign rdy[gi]      = !vld_reg[gi] || rdy[gi+1];
            assign vld_next[gi] = rdy[gi] ? vin[gi] : vld_reg[gi];
            assign en[gi]       = rdy[gi] && vin[gi];
            if (gi == 0)
            begin : g_first
                assign vin[gi] = s_tvalid;
            end
            else
            begin : g_rest
                assign vin[gi] = vld_reg[gi-1];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];

    // ------------------------------------------------------------------
    // Stage 1: unpack, form offset D = P - C
    // ------------------------------------------------------------------
    logic signed [EW-1:0] vec_next [NV][3];
    logic signed [EW-1:0] vec_reg  [NV][3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            vec_next[pitb_pkg::VEC_D][j] =
                EW'($signed(s_tdata[j*CW +: CW])) - EW'($signed(s_tdata[(3+j)*CW +: CW]));
            vec_next[pitb_pkg::VEC_E1][j] = $signed(s_tdata[6*CW + j*EW +: EW]);
            vec_next[pitb_pkg::VEC_E2][j] = $signed(s_tdata[6*CW + (3+j)*EW +: EW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            vec_reg <= vec_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-axis products for the five dot products
    // ------------------------------------------------------------------
    logic signed [PRW-1:0] term_next [ND][3];
    logic signed [PRW-1:0] term_reg  [ND][3];

    always_comb
    begin
        for (int k = 0; k < ND; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                term_next[k][j] = vec_reg[pitb_pkg::DOT_A[k]][j] * vec_reg[pitb_pkg::DOT_B[k]][j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            term_reg <= term_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum the three axes
    // ------------------------------------------------------------------
    logic signed [DW-1:0] dot_next [ND];
    logic signed [DW-1:0] dot_reg  [ND];

    always_comb
    begin
        for (int k = 0; k < ND; k++)
        begin
            dot_next[k] = DW'(term_reg[k][0]) + DW'(term_reg[k][1]) + DW'(term_reg[k][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            dot_reg <= dot_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: split each wide product into four half-width partials
    // ------------------------------------------------------------------
    logic signed [H-1:0]     a_hi [NM];
    logic signed [H-1:0]     b_hi [NM];
    logic        [H-1:0]     a_lo [NM];
    logic        [H-1:0]     b_lo [NM];
    logic signed [2*H-1:0]   pp_hh_next [NM];
    logic signed [2*H:0]     pp_hl_next [NM];
    logic signed [2*H:0]     pp_lh_next [NM];
    logic        [2*H-1:0]   pp_ll_next [NM];
    logic signed [2*H-1:0]   pp_hh_reg  [NM];
    logic signed [2*H:0]     pp_hl_reg  [NM];
    logic signed [2*H:0]     pp_lh_reg  [NM];
    logic        [2*H-1:0]   pp_ll_reg  [NM];

    always_comb
    begin
        for (int m = 0; m < NM; m++)
        begin
            a_hi[m] = $signed(dot_reg[pitb_pkg::MUL_A[m]][DW-1:H]);
            a_lo[m] = dot_reg[pitb_pkg::MUL_A[m]][H-1:0];
            b_hi[m] = $signed(dot_reg[pitb_pkg::MUL_B[m]][DW-1:H]);
            b_lo[m] = dot_reg[pitb_pkg::MUL_B[m]][H-1:0];
            pp_hh_next[m] = a_hi[m] * b_hi[m];
            pp_hl_next[m] = a_hi[m] * $signed({1'b0, b_lo[m]});
            pp_lh_next[m] = $signed({1'b0, a_lo[m]}) * b_hi[m];
            pp_ll_next[m] = a_lo[m] * b_lo[m];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            pp_hh_reg <= pp_hh_next;
            pp_hl_reg <= pp_hl_next;
            pp_lh_reg <= pp_lh_next;
            pp_ll_reg <= pp_ll_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine partials into full products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_next [NM];
    logic signed [PW-1:0] prod_reg  [NM];
    logic        [PW-1:0] hh_ext    [NM];
    logic        [PW-1:0] mid_ext   [NM];
    logic        [PW-1:0] ll_ext    [NM];

    always_comb
    begin
        for (int m = 0; m < NM; m++)
        begin
            hh_ext[m]    = PW'(pp_hh_reg[m]) << (2 * H);
            mid_ext[m]   = (PW'(pp_hl_reg[m]) + PW'(pp_lh_reg[m])) << H;
            ll_ext[m]    = PW'(pp_ll_reg[m]);
            prod_next[m] = $signed(hh_ext[m] + mid_ext[m] + ll_ext[m]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: Gram determinant and the two numerators
    // ------------------------------------------------------------------
    logic signed [GW-1:0] g_next;
    logic signed [GW-1:0] nu_next;
    logic signed [GW-1:0] nv_next;
    logic signed [GW-1:0] g_reg;
    logic signed [GW-1:0] nu_reg;
    logic signed [GW-1:0] nv_reg;

    assign g_next  = GW'(prod_reg[0]) - GW'(prod_reg[1]);
    assign nu_next = GW'(prod_reg[2]) - GW'(prod_reg[3]);
    assign nv_next = GW'(prod_reg[4]) - GW'(prod_reg[5]);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            g_reg  <= g_next;
            nu_reg <= nu_next;
            nv_reg <= nv_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: numerator sum and sign tests
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sum_next;
    logic signed [SW-1:0] sum_reg;
    logic signed [GW-1:0] gs_reg;
    logic                 pos_next;
    logic                 pos_reg;

    assign sum_next = SW'(nu_reg) + SW'(nv_reg);
    assign pos_next = !g_reg[GW-1]  && (|g_reg)
                   && !nu_reg[GW-1] && (|nu_reg)
                   && !nv_reg[GW-1] && (|nv_reg);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            sum_reg <= sum_next;
            gs_reg  <= g_reg;
            pos_reg <= pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: final compare, output register
    // ------------------------------------------------------------------
    logic inside_next;
    logic inside_reg;

    assign inside_next = pos_reg && (sum_reg < SW'(gs_reg));

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            inside_reg <= inside_next;
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {(pitb_pkg::OUT_TDATA_W - 1)'(0), inside_reg};

endmodule

`default_nettype wire

/* sv/pitb_checker.sv */
// Port-level checks for the point-in-triangle pipeline, bound to the top level.
// Depends on pitb_pkg and on point_in_triangle_barycentric being compiled first.
`timescale 1ns / 1ps
`default_nettype none

module pitb_checker #(
    parameter int  COORD_WIDTH = pitb_pkg::COORD_WIDTH_DEF,
    localparam int IN_BITS     = 12 * COORD_WIDTH + 6,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    // point, corner, edge1, edge2 fields, zero pad
    input wire logic [IN_TDATA_W-1:0]         s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    // inside_res, zero pad
    input wire logic [pitb_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // Pad bits above the result stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[pitb_pkg::OUT_TDATA_W-1:1] == '0))
        else $error("result pad bits not zero");

    // Input may stall only when every stage is full and the output is blocked
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with room in the pipeline");

    // Hold a stalled result beat, valid and data alike
    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat dropped or changed under stall");

    // An offered input beat carries known data
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown(s_tdata))
        else $error("input beat with unknown data");

    // No result beat is offered at the clock edge where reset release is first seen
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result beat straight after reset");

endmodule

bind point_in_triangle_barycentric pitb_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pitb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
